### rtl/slnc_pkg.sv
// Shared types, codes, reset values and helpers for the street light node controller.
package slnc_pkg;

   // Item kinds carried on the request channel
   typedef enum logic [1:0] {
      KIND_SAMPLE  = 2'd0,
      KIND_MESSAGE = 2'd1,
      KIND_TICK    = 2'd2
   } kind_type;

   // Neighbour message types
   typedef enum logic {
      MSG_MOTION     = 1'b0,
      MSG_BRIGHTNESS = 1'b1
   } msg_type_type;

   // Register word indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_NODE_X         = 3'd0,
      REG_NODE_Y         = 3'd1,
      REG_DARK_THRESHOLD = 3'd2,
      REG_HOLD_TICKS     = 3'd3,
      REG_FULL_LEVEL     = 3'd4,
      REG_DIM_LEVEL      = 3'd5
   } reg_addr_type;

   localparam int ADDR_WIDTH = 5;
   localparam int DATA_WIDTH = 32;

   // Register reset values
   localparam logic signed [15:0] RESET_NODE_X         = 16'sd1;
   localparam logic signed [15:0] RESET_NODE_Y         = 16'sd1;
   localparam logic        [11:0] RESET_DARK_THRESHOLD = 12'd1000;
   localparam logic        [15:0] RESET_HOLD_TICKS     = 16'd20;
   localparam logic        [6:0]  RESET_FULL_LEVEL     = 7'd100;
   localparam logic        [6:0]  RESET_DIM_LEVEL      = 7'd25;

   // LED bar thresholds
   localparam logic [6:0] BAR_STEP_1 = 7'd25;
   localparam logic [6:0] BAR_STEP_2 = 7'd50;
   localparam logic [6:0] BAR_STEP_3 = 7'd75;
   localparam logic [6:0] BAR_FULL   = 7'd100;

   typedef struct packed {
      logic signed [15:0] node_x;
      logic signed [15:0] node_y;
      logic        [11:0] dark_threshold;
      logic        [15:0] hold_ticks;
      logic        [6:0]  full_level;
      logic        [6:0]  dim_level;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic               pir_level;
      logic [11:0]        light_level;
      logic               msg_type;
      logic signed [15:0] msg_x;
      logic signed [15:0] msg_y;
      logic [6:0]         msg_brightness;
   } req_item_type;

   typedef struct packed {
      logic [6:0] brightness;
      logic [3:0] led_bar;
      logic       send_motion;
      logic       send_brightness;
   } rsp_item_type;

   typedef struct packed {
      logic       motion_flag;
      logic [7:0] neighbour_map;
   } core_status_type;

   // Four-segment level indicator
   function automatic logic [3:0] slnc_bar(input logic [6:0] level);
      logic [3:0] bar;
      bar    = 4'd0;
      bar[0] = (level >= BAR_STEP_1);
      bar[1] = (level >= BAR_STEP_2);
      bar[2] = (level >= BAR_STEP_3);
      bar[3] = (level == BAR_FULL);
      return bar;
   endfunction

endpackage

### rtl/slnc_csr.sv
// Configuration register file with an APB-style access port.
module slnc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [slnc_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [slnc_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [slnc_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                             pready,
   output slnc_pkg::cfg_type                cfg
);
   import slnc_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   logic         wr_en;
   reg_addr_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = reg_addr_type'(paddr[ADDR_WIDTH-1:2]);
   assign cfg     = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_NODE_X:         cfg_in.node_x         = pwdata[15:0];
            REG_NODE_Y:         cfg_in.node_y         = pwdata[15:0];
            REG_DARK_THRESHOLD: cfg_in.dark_threshold = pwdata[11:0];
            REG_HOLD_TICKS:     cfg_in.hold_ticks     = pwdata[15:0];
            REG_FULL_LEVEL:     cfg_in.full_level     = pwdata[6:0];
            REG_DIM_LEVEL:      cfg_in.dim_level      = pwdata[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux; signed registers read back sign-extended
   always_comb begin
      unique case (reg_sel)
         REG_NODE_X:         prdata = {{16{cfg_ff.node_x[15]}}, cfg_ff.node_x};
         REG_NODE_Y:         prdata = {{16{cfg_ff.node_y[15]}}, cfg_ff.node_y};
         REG_DARK_THRESHOLD: prdata = {20'd0, cfg_ff.dark_threshold};
         REG_HOLD_TICKS:     prdata = {16'd0, cfg_ff.hold_ticks};
         REG_FULL_LEVEL:     prdata = {25'd0, cfg_ff.full_level};
         REG_DIM_LEVEL:      prdata = {25'd0, cfg_ff.dim_level};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_x         <= RESET_NODE_X;
         cfg_ff.node_y         <= RESET_NODE_Y;
         cfg_ff.dark_threshold <= RESET_DARK_THRESHOLD;
         cfg_ff.hold_ticks     <= RESET_HOLD_TICKS;
         cfg_ff.full_level     <= RESET_FULL_LEVEL;
         cfg_ff.dim_level      <= RESET_DIM_LEVEL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/slnc_core.sv
// Node state (motion, hold timer, neighbour map, lamp level) and per-item update logic.
module slnc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  slnc_pkg::cfg_type          cfg,
   input  slnc_pkg::req_item_type     item,
   input  logic                       advance,
   output slnc_pkg::rsp_item_type     result,
   output slnc_pkg::core_status_type  status
);
   import slnc_pkg::*;

   logic        pir_prev_ff,    pir_prev_in;
   logic        motion_ff,      motion_in;
   logic [15:0] hold_ff,        hold_in;
   logic [7:0]  nmap_ff,        nmap_in;
   logic [6:0]  level_ff,       level_in;

   logic signed [16:0] dx;
   logic signed [16:0] dy;
   logic               dx_near;
   logic               dy_near;
   logic [1:0]         col;
   logic [1:0]         row;
   logic [3:0]         cell9;
   logic [3:0]         cell8;
   logic [2:0]         nbr_bit;
   logic [6:0]         target;
   logic               send_m;
   logic               send_b;

   // Sender offset from this node and its neighbour bit (centre cell skipped)
   always_comb begin
      dx      = {item.msg_x[15], item.msg_x} - {cfg.node_x[15], cfg.node_x};
      dy      = {item.msg_y[15], item.msg_y} - {cfg.node_y[15], cfg.node_y};
      dx_near = (dx == -17'sd1) || (dx == 17'sd0) || (dx == 17'sd1);
      dy_near = (dy == -17'sd1) || (dy == 17'sd0) || (dy == 17'sd1);
      col     = dx[1:0] + 2'd1;
      row     = dy[1:0] + 2'd1;
      cell9   = ({2'd0, row} * 4'd3) + {2'd0, col};
      cell8   = (cell9 > 4'd4) ? (cell9 - 4'd1) : cell9;
      nbr_bit = cell8[2:0];
   end

   // Next state per item kind
   always_comb begin
      pir_prev_in = pir_prev_ff;
      motion_in   = motion_ff;
      hold_in     = hold_ff;
      nmap_in     = nmap_ff;
      level_in    = level_ff;
      target      = 7'd0;
      send_m      = 1'b0;
      send_b      = 1'b0;
      case (kind_type'(item.kind))
         KIND_SAMPLE: begin
            if (!pir_prev_ff && item.pir_level) begin
               send_m    = 1'b1;
               motion_in = 1'b1;
               hold_in   = cfg.hold_ticks;
            end
            pir_prev_in = item.pir_level;
            if (item.light_level < cfg.dark_threshold) begin
               if (motion_in) begin
                  target = cfg.full_level;
               end else if (nmap_ff != 8'd0) begin
                  target = cfg.dim_level;
               end
            end
            send_b   = (target != level_ff);
            level_in = target;
         end
         KIND_MESSAGE: begin
            if (dx_near && dy_near && !((dx == 17'sd0) && (dy == 17'sd0))) begin
               if (msg_type_type'(item.msg_type) == MSG_MOTION) begin
                  nmap_in[nbr_bit] = 1'b1;
               end else if (item.msg_brightness == 7'd0) begin
                  nmap_in[nbr_bit] = 1'b0;
               end
            end
         end
         KIND_TICK: begin
            if (hold_ff <= 16'd1) begin
               motion_in = 1'b0;
               hold_in   = cfg.hold_ticks;
            end else begin
               hold_in = hold_ff - 16'd1;
            end
         end
         default: ;
      endcase
   end

   // Result for the item in flight
   always_comb begin
      result.brightness      = level_in;
      result.led_bar         = slnc_bar(level_in);
      result.send_motion     = send_m;
      result.send_brightness = send_b;
      status.motion_flag     = motion_ff;
      status.neighbour_map   = nmap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pir_prev_ff <= 1'b0;
         motion_ff   <= 1'b0;
         hold_ff     <= RESET_HOLD_TICKS;
         nmap_ff     <= 8'd0;
         level_ff    <= 7'd0;
      end else if (advance) begin
         pir_prev_ff <= pir_prev_in;
         motion_ff   <= motion_in;
         hold_ff     <= hold_in;
         nmap_ff     <= nmap_in;
         level_ff    <= level_in;
      end
   end

endmodule

### rtl/street_light_node_controller.sv
// Top level of the street light node controller: request register, core, result register.
// Each request (sensor sample, neighbour message or time tick) gives exactly one response
// carrying the lamp level, its LED bar and the motion/brightness broadcast flags. A request
// is registered on transfer, evaluated against the node state and written to the response
// register, so the block sustains one item per clock unless a response waits on rsp_stall;
// the response is valid after the item passes both registers. Together the two registers
// hold two items, so a new request is taken while a finished response waits on rsp_stall.
// The user must write configuration through the APB-style port while idle (not enforced).
module street_light_node_controller (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_kind,
   input  logic                             req_pir_level,
   input  logic [11:0]                      req_light_level,
   input  logic                             req_msg_type,
   input  logic signed [15:0]               req_msg_x,
   input  logic signed [15:0]               req_msg_y,
   input  logic [6:0]                       req_msg_brightness,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [6:0]                       rsp_brightness,
   output logic [3:0]                       rsp_led_bar,
   output logic                             rsp_send_motion,
   output logic                             rsp_send_brightness,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [slnc_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [slnc_pkg::DATA_WIDTH-1:0]  pwdata,
   output logic [slnc_pkg::DATA_WIDTH-1:0]  prdata,
   output logic                             pready
);
   import slnc_pkg::*;

   cfg_type         cfg;
   req_item_type    req_item_ff;
   req_item_type    req_item_in;
   logic            req_valid_ff, req_valid_in;
   rsp_item_type    rsp_item_ff;
   rsp_item_type    core_result;
   logic            rsp_valid_ff, rsp_valid_in;
   core_status_type core_status;
   logic            out_ready;
   logic            advance;
   logic            req_take;

   slnc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slnc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (req_item_ff),
      .advance (advance),
      .result  (core_result),
      .status  (core_status)
   );

   // Pipeline flow control
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_ready;
   assign req_stall = req_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      req_item_in.kind           = req_kind;
      req_item_in.pir_level      = req_pir_level;
      req_item_in.light_level    = req_light_level;
      req_item_in.msg_type       = req_msg_type;
      req_item_in.msg_x          = req_msg_x;
      req_item_in.msg_y          = req_msg_y;
      req_item_in.msg_brightness = req_msg_brightness;
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_item_ff <= core_result;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_brightness      = rsp_item_ff.brightness;
   assign rsp_led_bar         = rsp_item_ff.led_bar;
   assign rsp_send_motion     = rsp_item_ff.send_motion;
   assign rsp_send_brightness = rsp_item_ff.send_brightness;

   // A held request is never dropped while the response side is blocked
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && !advance) |=> req_valid_ff)
      else $error("request register lost an item while blocked");

   // A motion broadcast always leaves the motion flag set
   a_motion_flag: assert property (@(posedge clock) disable iff (reset)
      (advance && core_result.send_motion) |=> core_status.motion_flag)
      else $error("motion broadcast without motion flag");

   // The LED bar always matches the reported level
   a_bar_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_led_bar == slnc_bar(rsp_brightness)))
      else $error("led bar does not match brightness");

   // Back-pressure only when both the request and response registers are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (req_valid_ff && rsp_valid_ff))
      else $error("request stalled with free storage");

endmodule

### tb/street_light_node_controller_tb.sv
// Self-checking testbench for the street light node controller: directed and random traffic.
module street_light_node_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import slnc_pkg::*;

   // Kind code the block must ignore
   localparam logic [1:0] KIND_UNUSED     = 2'd3;
   localparam int         CYCLE_LIMIT     = 400000;
   localparam int         ITEMS_PER_PHASE = 125;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_item_type          req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [6:0]            rsp_brightness;
   logic [3:0]            rsp_led_bar;
   logic                  rsp_send_motion;
   logic                  rsp_send_brightness;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr     = '0;
   logic [DATA_WIDTH-1:0] pwdata    = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   // Lamp state as the testbench expects it
   cfg_type      lamp_cfg;
   logic         lamp_pir_prev;
   logic         lamp_motion;
   logic [15:0]  lamp_hold;
   logic [7:0]   lamp_nmap;
   logic [6:0]   lamp_level;
   rsp_item_type lamp_expect_q[$];

   int kind_count[4];
   int rsp_count   = 0;
   int csr_writes  = 0;
   int phase_count = 0;
   int error_count = 0;
   int cycle_count = 0;

   street_light_node_controller u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_item.kind),
      .req_pir_level       (req_item.pir_level),
      .req_light_level     (req_item.light_level),
      .req_msg_type        (req_item.msg_type),
      .req_msg_x           (req_item.msg_x),
      .req_msg_y           (req_item.msg_y),
      .req_msg_brightness  (req_item.msg_brightness),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_brightness      (rsp_brightness),
      .rsp_led_bar         (rsp_led_bar),
      .rsp_send_motion     (rsp_send_motion),
      .rsp_send_brightness (rsp_send_brightness),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still due",
                  cycle_count, lamp_expect_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR: %s", msg);
   endtask

   // Idle run length: mostly short, now and then long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(1, 2);
      else if (pick < 90) return $urandom_range(3, 8);
      else if (pick < 98) return $urandom_range(9, 20);
      else return $urandom_range(30, 60);
   endfunction

   // Receiver back-pressure, with quiet stretches
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b0;
            n = $urandom_range(50, 150);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            n = idle_length();
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 8);
         end
         repeat (n) @(negedge clock);
      end
   end

   task automatic reset_lamp_model();
      lamp_cfg.node_x         = RESET_NODE_X;
      lamp_cfg.node_y         = RESET_NODE_Y;
      lamp_cfg.dark_threshold = RESET_DARK_THRESHOLD;
      lamp_cfg.hold_ticks     = RESET_HOLD_TICKS;
      lamp_cfg.full_level     = RESET_FULL_LEVEL;
      lamp_cfg.dim_level      = RESET_DIM_LEVEL;
      lamp_pir_prev = 1'b0;
      lamp_motion   = 1'b0;
      lamp_hold     = RESET_HOLD_TICKS;
      lamp_nmap     = '0;
      lamp_level    = '0;
   endtask

   // Advance the expected lamp state by one item and queue the response it gives
   task automatic predict_lamp(input req_item_type it);
      rsp_item_type r;
      int           dx;
      int           dy;
      int           nbr_idx;
      logic [6:0]   target;
      r.send_motion     = 1'b0;
      r.send_brightness = 1'b0;
      case (it.kind)
         KIND_SAMPLE: begin
            // rising PIR edge restarts the hold window
            if (!lamp_pir_prev && it.pir_level) begin
               r.send_motion = 1'b1;
               lamp_motion   = 1'b1;
               lamp_hold     = lamp_cfg.hold_ticks;
            end
            lamp_pir_prev = it.pir_level;
            if (it.light_level < lamp_cfg.dark_threshold) begin
               if (lamp_motion) target = lamp_cfg.full_level;
               else if (lamp_nmap != 8'd0) target = lamp_cfg.dim_level;
               else target = 7'd0;
            end else begin
               target = 7'd0;
            end
            r.send_brightness = (target != lamp_level);
            lamp_level = target;
         end
         KIND_MESSAGE: begin
            dx = $signed(it.msg_x) - $signed(lamp_cfg.node_x);
            dy = $signed(it.msg_y) - $signed(lamp_cfg.node_y);
            // only the eight surrounding cells count, centre skipped in numbering
            if (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1 && !(dx == 0 && dy == 0)) begin
               nbr_idx = (dx + 1) + (dy + 1) * 3;
               if (nbr_idx > 4) nbr_idx = nbr_idx - 1;
               if (it.msg_type == MSG_MOTION) lamp_nmap[nbr_idx] = 1'b1;
               else if (it.msg_brightness == 7'd0) lamp_nmap[nbr_idx] = 1'b0;
            end
         end
         KIND_TICK: begin
            if (lamp_hold <= 16'd1) begin
               lamp_motion = 1'b0;
               lamp_hold   = lamp_cfg.hold_ticks;
            end else begin
               lamp_hold = lamp_hold - 16'd1;
            end
         end
         default: begin
         end
      endcase
      r.brightness = lamp_level;
      r.led_bar    = {lamp_level == 7'd100, lamp_level >= 7'd75,
                      lamp_level >= 7'd50, lamp_level >= 7'd25};
      lamp_expect_q.push_back(r);
   endtask

   // Response checker
   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (lamp_expect_q.size() == 0) begin
            flag_error($sformatf("unexpected response transfer: bright=%0d bar=%h m=%b b=%b",
                       rsp_brightness, rsp_led_bar, rsp_send_motion, rsp_send_brightness));
         end else begin
            want = lamp_expect_q.pop_front();
            if (rsp_brightness !== want.brightness || rsp_led_bar !== want.led_bar ||
                rsp_send_motion !== want.send_motion ||
                rsp_send_brightness !== want.send_brightness) begin
               flag_error($sformatf({"response %0d: expected bright=%0d bar=%h m=%b b=%b,",
                          " got bright=%0d bar=%h m=%b b=%b"}, rsp_count,
                          want.brightness, want.led_bar, want.send_motion,
                          want.send_brightness, rsp_brightness, rsp_led_bar,
                          rsp_send_motion, rsp_send_brightness));
            end
         end
      end
   end

   // One request transfer, sometimes preceded by a random idle gap
   task automatic send_item(input req_item_type it);
      int gap;
      gap = ($urandom_range(0, 99) < 55) ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_lamp(it);
      kind_count[it.kind]++;
   endtask

   // Stop sending and let every outstanding response come back
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lamp_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB setup + access
   task automatic csr_access(input logic wr, input reg_addr_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write a register, mirror it in the expected config, read it back
   task automatic set_reg(input reg_addr_type idx, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] mask;
      csr_access(1'b1, idx, value, readback);
      csr_writes++;
      case (idx)
         REG_NODE_X: begin
            lamp_cfg.node_x = value[15:0];
            mask = 32'h0000_FFFF;
         end
         REG_NODE_Y: begin
            lamp_cfg.node_y = value[15:0];
            mask = 32'h0000_FFFF;
         end
         REG_DARK_THRESHOLD: begin
            lamp_cfg.dark_threshold = value[11:0];
            mask = 32'h0000_0FFF;
         end
         REG_HOLD_TICKS: begin
            lamp_cfg.hold_ticks = value[15:0];
            mask = 32'h0000_FFFF;
         end
         REG_FULL_LEVEL: begin
            lamp_cfg.full_level = value[6:0];
            mask = 32'h0000_007F;
         end
         default: begin
            lamp_cfg.dim_level = value[6:0];
            mask = 32'h0000_007F;
         end
      endcase
      csr_access(1'b0, idx, '0, readback);
      if ((readback & mask) != (value & mask))
         flag_error($sformatf("register %s readback: expected %h, got %h",
                    idx.name(), value & mask, readback & mask));
   endtask

   // Item of the given kind with every other field randomized
   function automatic req_item_type noise_item(input logic [1:0] kind);
      req_item_type it;
      it.kind           = kind;
      it.pir_level      = 1'($urandom_range(0, 1));
      it.light_level    = 12'($urandom_range(0, 4095));
      it.msg_type       = 1'($urandom_range(0, 1));
      it.msg_x          = 16'($urandom_range(0, 65535));
      it.msg_y          = 16'($urandom_range(0, 65535));
      it.msg_brightness = 7'($urandom_range(0, 100));
      return it;
   endfunction

   function automatic req_item_type make_sample(input logic pir, input logic [11:0] light);
      req_item_type it;
      it = noise_item(KIND_SAMPLE);
      it.pir_level   = pir;
      it.light_level = light;
      return it;
   endfunction

   function automatic req_item_type make_message(input msg_type_type mtype,
                                                 input logic [15:0] x, input logic [15:0] y,
                                                 input logic [6:0] level);
      req_item_type it;
      it = noise_item(KIND_MESSAGE);
      it.msg_type       = mtype;
      it.msg_x          = x;
      it.msg_y          = y;
      it.msg_brightness = level;
      return it;
   endfunction

   // Mostly meaningful traffic: PIR level changes, readings near the threshold, nearby senders
   function automatic req_item_type random_item();
      req_item_type it;
      int           pick;
      int           t;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         it = noise_item(KIND_SAMPLE);
         it.pir_level = ($urandom_range(0, 9) < 3) ? !lamp_pir_prev : lamp_pir_prev;
         if ($urandom_range(0, 1) == 1) begin
            t = int'(lamp_cfg.dark_threshold) + int'($urandom_range(0, 4)) - 2;
            if (t < 0) t = 0;
            if (t > 4095) t = 4095;
            it.light_level = t[11:0];
         end
      end else if (pick < 75) begin
         it = noise_item(KIND_MESSAGE);
         if ($urandom_range(0, 4) != 0) begin
            it.msg_x = lamp_cfg.node_x + 16'(int'($urandom_range(0, 2)) - 1);
            it.msg_y = lamp_cfg.node_y + 16'(int'($urandom_range(0, 2)) - 1);
         end
         if ($urandom_range(0, 1) == 1) it.msg_brightness = '0;
      end else if (pick < 95) begin
         it = noise_item(KIND_TICK);
      end else begin
         it = noise_item(KIND_UNUSED);
      end
      return it;
   endfunction

   // Lamp level against light and PIR at reset settings
   task automatic test_sample_levels();
      send_item(make_sample(1'b0, 12'd0));
      send_item(make_sample(1'b1, 12'd999));
      send_item(make_sample(1'b1, 12'd999));
      send_item(make_sample(1'b0, 12'd1000));
      send_item(make_sample(1'b0, 12'd4095));
      send_item(make_sample(1'b0, 12'd0));
   endtask

   // Neighbour bits: corners, own cell, far senders, brightness messages, unused kind
   task automatic test_neighbour_cells();
      send_item(make_message(MSG_MOTION, 16'sd0, 16'sd0, 7'd0));
      send_item(make_message(MSG_MOTION, 16'sd2, 16'sd2, 7'd100));
      send_item(make_message(MSG_MOTION, 16'sd1, 16'sd1, 7'd0));
      send_item(make_message(MSG_MOTION, 16'sd3, 16'sd1, 7'd0));
      send_item(make_message(MSG_MOTION, 16'h8000, 16'h7FFF, 7'd0));
      send_item(make_message(MSG_BRIGHTNESS, 16'sd0, 16'sd0, 7'd100));
      send_item(make_message(MSG_BRIGHTNESS, 16'sd0, 16'sd0, 7'd0));
      send_item(noise_item(KIND_UNUSED));
   endtask

   // Zero hold time behaves like one tick
   task automatic test_hold_expiry();
      wait_idle();
      set_reg(REG_HOLD_TICKS, 32'd0);
      send_item(make_sample(1'b0, 12'd0));
      send_item(make_sample(1'b1, 12'd0));
      send_item(noise_item(KIND_TICK));
      send_item(make_sample(1'b1, 12'd0));
   endtask

   // Node at the grid corner, threshold at max, level above 100 on the bar
   task automatic test_level_extremes();
      wait_idle();
      set_reg(REG_NODE_X, 32'h0000_8000);
      set_reg(REG_NODE_Y, 32'h0000_7FFF);
      set_reg(REG_DARK_THRESHOLD, 32'd4095);
      set_reg(REG_FULL_LEVEL, 32'd127);
      set_reg(REG_DIM_LEVEL, 32'd0);
      send_item(make_message(MSG_MOTION, 16'h8001, 16'h7FFF, 7'd0));
      send_item(make_sample(1'b0, 12'd4094));
      send_item(make_sample(1'b1, 12'd4094));
      send_item(make_sample(1'b1, 12'd4095));
      send_item(noise_item(KIND_TICK));
   endtask

   // One configuration phase of random traffic
   task automatic run_phase(input cfg_type c);
      wait_idle();
      set_reg(REG_NODE_X, {16'd0, c.node_x});
      set_reg(REG_NODE_Y, {16'd0, c.node_y});
      set_reg(REG_DARK_THRESHOLD, {20'd0, c.dark_threshold});
      set_reg(REG_HOLD_TICKS, {16'd0, c.hold_ticks});
      set_reg(REG_FULL_LEVEL, {25'd0, c.full_level});
      set_reg(REG_DIM_LEVEL, {25'd0, c.dim_level});
      phase_count++;
      repeat (ITEMS_PER_PHASE) send_item(random_item());
   endtask

   task automatic test_random_phases();
      cfg_type c;
      c = '{node_x: 16'sd1, node_y: 16'sd1, dark_threshold: 12'd1000, hold_ticks: 16'd20,
            full_level: 7'd100, dim_level: 7'd25};
      run_phase(c);
      c = '{node_x: 16'h8000, node_y: 16'h7FFF, dark_threshold: 12'd4095, hold_ticks: 16'd3,
            full_level: 7'd100, dim_level: 7'd50};
      run_phase(c);
      c = '{node_x: 16'sd0, node_y: 16'sd0, dark_threshold: 12'd0, hold_ticks: 16'd1,
            full_level: 7'd75, dim_level: 7'd100};
      run_phase(c);
      c = '{node_x: 16'h7FFF, node_y: 16'h8000, dark_threshold: 12'd2048,
            hold_ticks: 16'hFFFF, full_level: 7'd0, dim_level: 7'd74};
      run_phase(c);
      c.node_x         = 16'($urandom_range(0, 65535));
      c.node_y         = 16'($urandom_range(0, 65535));
      c.dark_threshold = 12'($urandom_range(1, 4095));
      c.hold_ticks     = 16'd0;
      c.full_level     = 7'd127;
      c.dim_level      = 7'($urandom_range(0, 127));
      run_phase(c);
   endtask

   // Test sequence
   initial begin
      reset_lamp_model();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_sample_levels();
      test_neighbour_cells();
      test_hold_expiry();
      test_level_extremes();
      test_random_phases();
      wait_idle();
      repeat (8) @(posedge clock);
      if (lamp_expect_q.size() != 0)
         flag_error($sformatf("%0d responses never arrived", lamp_expect_q.size()));
      $display("Sent %0d samples, %0d neighbour messages, %0d ticks, %0d unused-kind items;",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
      $display("checked %0d responses over %0d random phases with %0d register writes.",
               rsp_count, phase_count, csr_writes);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d errors", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### street_light_node_controller.f
rtl/slnc_pkg.sv
rtl/slnc_csr.sv
rtl/slnc_core.sv
rtl/street_light_node_controller.sv
tb/street_light_node_controller_tb.sv
